// ===== rtl/core/plc_pkg.sv =====
// Shared types and codes for the positional list buffer.
// Holds the item structs, command and status codes and the cell control bundle.
// No dependencies.
`default_nettype none

package plc_pkg;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [POS_W-1:0]         count;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] tail_value;
        logic signed [DATA_W-1:0] read_value;
    } out_item_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage : plc_pkg

`default_nettype wire

// ===== rtl/core/plc_cell.sv =====
// One storage cell of the list row: holds a single entry and shifts with its neighbors.
// Depends on plc_pkg.
`default_nettype none

module plc_cell #(
    parameter int PW  = 12,
    parameter int IDX = 0
) (
    input  wire logic                              aclk,
    input  wire plc_pkg::cell_ctl_t                ctl,
    input  wire logic [PW-1:0]                     pos0,
    input  wire logic [PW-1:0]                     sel_idx,
    input  wire logic signed [plc_pkg::DATA_W-1:0] prev_data,
    input  wire logic signed [plc_pkg::DATA_W-1:0] next_data,
    output logic signed [plc_pkg::DATA_W-1:0]      data,
    output logic signed [plc_pkg::DATA_W-1:0]      tap
);
    import plc_pkg::*;

    localparam logic [PW-1:0] IDX_X = PW'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (IDX_X == pos0) begin
                data_next = ctl.value;
            end else if (IDX_X > pos0) begin
                data_next = prev_data;
            end
        end else if (ctl.del && (IDX_X >= pos0)) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (IDX_X == sel_idx) ? data_reg : '0;

endmodule : plc_cell

`default_nettype wire

// ===== rtl/core/positional_list_buffer.sv =====
// Top level of the positional list buffer: control, count and the row of cells.
// Depends on plc_pkg and plc_cell.
//
// Usage:
//   s_valid/s_ready/s_item carry one command item: insert, delete or read at a
//   1-based position. m_valid/m_ready/m_item carry one result item per command:
//   status, entry count, head and tail values and the read or removed value.
//   In the accept cycle every cell compares its own index with the position
//   and shifts locally, and the entry at the position is captured through the
//   shared cell tap. While the result is pending the same tap picks the new
//   tail, and the result loads the output register once that register is free.
//   s_ready stays low from acceptance until then, because the single shared tap
//   serves both steps; m_valid rises as the result loads the output register.
//   A new item is accepted while a finished result still waits in the output
//   register; its result then holds until m_ready frees that register.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result. Entry contents are not cleared; positions beyond the count are
//   never read.
//   Out-of-range positions and inserts into a full list change nothing.
`default_nettype none

module positional_list_buffer #(
    parameter int DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire plc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output plc_pkg::out_item_t      m_item
);
    import plc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    // Compare width: wide enough for the count, a position and their sum
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [PW-1:0] DEPTH_X = PW'(DEPTH);
    localparam logic [PW-1:0] ONE_X   = PW'(1);

    // Control and count
    logic          pend_reg;
    logic          pend_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic signed [DATA_W-1:0] readv_reg;
    logic signed [DATA_W-1:0] readv_next;

    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_item_reg;
    out_item_t m_item_next;

    logic      accept;
    logic      load_out;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pos0;
    logic [PW-1:0] sel_idx;
    logic      pos_zero;
    logic      op_ok;
    cell_ctl_t ctl;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_tap  [DEPTH];
    logic signed [DATA_W-1:0] tap_or;

    assign s_ready  = !pend_reg;
    assign accept   = s_valid && s_ready;
    assign load_out = pend_reg && (!m_valid_reg || m_ready);

    assign pos_x    = PW'(s_item.position);
    assign cnt_x    = PW'(count_reg);
    assign pos0     = pos_x - ONE_X;
    assign pos_zero = (s_item.position == '0);

    // Shared tap: position during accept, new tail while the result forms
    assign sel_idx = pend_reg ? (cnt_x - ONE_X) : pos0;

    // Decode the command and check its range
    always_comb begin
        status_next = ST_OK;
        case (s_item.cmd)
            CMD_INSERT: begin
                if (pos_zero || (pos_x > (cnt_x + ONE_X))) begin
                    status_next = ST_RANGE;
                end else if (cnt_x == DEPTH_X) begin
                    status_next = ST_FULL;
                end
            end
            CMD_DELETE, CMD_READ: begin
                if (pos_zero || (pos_x > cnt_x)) begin
                    status_next = ST_RANGE;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    assign op_ok = (status_next == ST_OK);

    always_comb begin
        ctl.ins   = accept && op_ok && (s_item.cmd == CMD_INSERT);
        ctl.del   = accept && op_ok && (s_item.cmd == CMD_DELETE);
        ctl.value = s_item.value;
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.del) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Capture the entry at the position before the shift lands
    always_comb begin
        readv_next = readv_reg;
        if (accept) begin
            readv_next = '0;
            if (op_ok && ((s_item.cmd == CMD_DELETE) || (s_item.cmd == CMD_READ))) begin
                readv_next = tap_or;
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (accept) begin
            pend_next = 1'b1;
        end else if (load_out) begin
            pend_next = 1'b0;
        end
    end

    // Result assembly from the updated row
    always_comb begin
        m_item_next            = m_item_reg;
        m_valid_next           = m_valid_reg;
        if (load_out) begin
            m_valid_next           = 1'b1;
            m_item_next.status     = status_reg;
            m_item_next.count      = POS_W'(count_reg);
            m_item_next.read_value = readv_reg;
            if (count_reg == '0) begin
                m_item_next.head_value = '0;
                m_item_next.tail_value = '0;
            end else begin
                m_item_next.head_value = cell_data[0];
                m_item_next.tail_value = tap_or;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= accept ? status_next : status_reg;
        readv_reg  <= readv_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Row of cells; each shifts toward its neighbor by its own index compare
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        plc_cell #(
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .pos0      (pos0),
            .sel_idx   (sel_idx),
            .prev_data ((i == 0) ? s_item.value : cell_data[(i == 0) ? 0 : i - 1]),
            .next_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
            .data      (cell_data[i]),
            .tap       (cell_tap[i])
        );
    end

    // Combine the one-hot taps
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

endmodule : positional_list_buffer

`default_nettype wire
